>>> hdl/rrd_pkg.sv
// ----------------------------------------------------------------------------
// RPC reply deframer package
// Shared types and constants for the record-marking reply deframer.
// ----------------------------------------------------------------------------
package rrd_pkg;

    localparam int DATA_W      = 8;
    localparam int LEN_W       = 31;
    localparam int XID_W       = 32;
    localparam int TOTAL_W     = 32;
    localparam int SKIP_W      = 33;
    localparam int HDR_CNT_W   = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HDR_CNT_W-1:0] HDR_BYTES = 3'd4;
    localparam logic [LEN_W-1:0]     MAX_LEN_RESET = 31'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_XID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD_LEN = 1'b1;

    localparam logic [XID_W-1:0] MSG_REPLY      = 32'd1;
    localparam logic [XID_W-1:0] REPLY_ACCEPTED = 32'd0;
    localparam logic [XID_W-1:0] ACCEPT_SUCCESS = 32'd0;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_XID   = 4'd1,
        PH_MTYPE = 4'd2,
        PH_RSTAT = 4'd3,
        PH_VFLAV = 4'd4,
        PH_VLEN  = 4'd5,
        PH_VSKIP = 4'd6,
        PH_ASTAT = 4'd7,
        PH_BODY  = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_XID      = 3'd1,
        ST_NOTREPLY = 3'd2,
        ST_DENIED   = 3'd3,
        ST_ACCEPT   = 3'd4,
        ST_SHORT    = 3'd5,
        ST_TOOLONG  = 3'd6
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] body_byte;
        logic              byte_valid;
        logic              record_last;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hdl/rrd_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying received stream bytes into the deframer.
// ----------------------------------------------------------------------------
interface rrd_stream_if
    import rrd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              new_reply;

    modport source (output valid, output data_byte, output new_reply, input ready);
    modport sink (input valid, input data_byte, input new_reply, output ready);
endinterface

>>> hdl/rrd_reply_if.sv
// ----------------------------------------------------------------------------
// Reply channel
// Valid/ready channel carrying body bytes and record status out.
// ----------------------------------------------------------------------------
interface rrd_reply_if
    import rrd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] body_byte;
    logic              byte_valid;
    logic              record_last;
    logic [2:0]        status;

    modport source (output valid, output body_byte, output byte_valid,
                    output record_last, output status, input ready);
    modport sink (input valid, input body_byte, input byte_valid,
                  input record_last, input status, output ready);
endinterface

>>> hdl/rpc_record_reply_deframer_unit.sv
// ----------------------------------------------------------------------------
// RPC record reply deframer
// Strips record-marking headers from a reply stream, checks the reply header
// and passes body bytes out with an end-of-record or error status.
// ----------------------------------------------------------------------------
// The block takes one stream byte in every clock cycle. Each byte is parsed
// in the cycle it is accepted, including the fragment length sum and limit
// check when a header completes, and any result enters a two-entry queue
// ahead of the output register, which presents it on the reply channel.
// Input is held off only while that queue is full, which happens only when
// the reply side stalls.
module rpc_record_reply_deframer_unit
    import rrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rrd_stream_if.sink            stream,
    rrd_reply_if.source           reply,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    queue_status_t q_status;
    logic          push;
    result_t       push_data;
    logic          pop;
    result_t       pop_data;

    rrd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    rrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    rrd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (pop_data),
        .pop      (pop),
        .reply    (reply)
    );

endmodule

>>> hdl/rrd_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts stream bytes, strips fragment headers, checks the reply header and
// classifies each byte, pushing any result into the queue.
// ----------------------------------------------------------------------------
module rrd_front
    import rrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rrd_stream_if.sink            stream,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  queue_status_t         q_status,
    output logic                  push,
    output result_t               push_data
);

    logic [XID_W-1:0]     xid_reg;
    logic [LEN_W-1:0]     max_len_reg;
    phase_t               phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0]     frag_rem_reg, frag_rem_next;
    logic                 frag_last_reg, frag_last_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [1:0]           word_idx_reg, word_idx_next;
    logic [XID_W-1:0]     word_reg, word_next;
    logic [SKIP_W-1:0]    skip_reg, skip_next;
    logic                 take;
    logic                 body_hit;
    logic                 frag_end;
    logic                 stop;

    assign stream.ready = !q_status.full;
    assign take         = stream.valid && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xid_reg     <= '0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_EXPECTED_XID:   xid_reg     <= cfg_data;
                REG_MAX_RECORD_LEN: max_len_reg <= cfg_data[LEN_W-1:0];
                default:            xid_reg     <= xid_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hdr_cnt_reg   <= '0;
            frag_rem_reg  <= '0;
            frag_last_reg <= 1'b0;
            total_reg     <= '0;
            word_idx_reg  <= '0;
            word_reg      <= '0;
            skip_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            frag_rem_reg  <= frag_rem_next;
            frag_last_reg <= frag_last_next;
            total_reg     <= total_next;
            word_idx_reg  <= word_idx_next;
            word_reg      <= word_next;
            skip_reg      <= skip_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        frag_rem_next  = frag_rem_reg;
        frag_last_next = frag_last_reg;
        total_next     = total_reg;
        word_idx_next  = word_idx_reg;
        word_next      = word_reg;
        skip_next      = skip_reg;
        push           = 1'b0;
        push_data      = '0;
        body_hit       = 1'b0;
        frag_end       = 1'b0;
        stop           = 1'b0;

        if (take)
        begin
            if (stream.new_reply)
            begin
                phase_next     = PH_XID;
                hdr_cnt_next   = '0;
                frag_rem_next  = '0;
                frag_last_next = 1'b0;
                total_next     = '0;
                word_idx_next  = '0;
                word_next      = '0;
                skip_next      = '0;
            end

            if (phase_next != PH_IDLE)
            begin
                if (hdr_cnt_next != HDR_BYTES)
                begin
                    if (hdr_cnt_next == '0)
                    begin
                        frag_last_next = stream.data_byte[7];
                        frag_rem_next  = {24'd0, stream.data_byte[6:0]};
                    end
                    else
                    begin
                        frag_rem_next = {frag_rem_next[LEN_W-DATA_W-1:0], stream.data_byte};
                    end
                    hdr_cnt_next = hdr_cnt_next + 3'd1;
                    if (hdr_cnt_next == HDR_BYTES)
                    begin
                        total_next = total_next + {1'b0, frag_rem_next};
                        if (total_next > {1'b0, max_len_reg})
                        begin
                            push                  = 1'b1;
                            push_data.record_last = 1'b1;
                            push_data.status      = ST_TOOLONG;
                            stop                  = 1'b1;
                        end
                        else if (frag_rem_next == '0)
                        begin
                            frag_end = 1'b1;
                        end
                    end
                end
                else
                begin
                    frag_rem_next = frag_rem_next - 31'd1;
                    case (phase_next)
                        PH_BODY:
                        begin
                            body_hit = 1'b1;
                        end
                        PH_VSKIP:
                        begin
                            skip_next = skip_next - 33'd1;
                            if (skip_next == '0)
                            begin
                                phase_next = PH_ASTAT;
                            end
                        end
                        default:
                        begin
                            word_next     = {word_next[XID_W-DATA_W-1:0], stream.data_byte};
                            word_idx_next = word_idx_next + 2'd1;
                            if (word_idx_next == 2'd0)
                            begin
                                case (phase_next)
                                    PH_XID:
                                    begin
                                        if (word_next != xid_reg)
                                        begin
                                            push_data.status = ST_XID;
                                            stop             = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_MTYPE;
                                        end
                                    end
                                    PH_MTYPE:
                                    begin
                                        if (word_next != MSG_REPLY)
                                        begin
                                            push_data.status = ST_NOTREPLY;
                                            stop             = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_RSTAT;
                                        end
                                    end
                                    PH_RSTAT:
                                    begin
                                        if (word_next != REPLY_ACCEPTED)
                                        begin
                                            push_data.status = ST_DENIED;
                                            stop             = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_VFLAV;
                                        end
                                    end
                                    PH_VFLAV:
                                    begin
                                        phase_next = PH_VLEN;
                                    end
                                    PH_VLEN:
                                    begin
                                        skip_next = {1'b0, word_next}
                                                  + {31'd0, 2'd0 - word_next[1:0]};
                                        phase_next = (skip_next != '0) ? PH_VSKIP : PH_ASTAT;
                                    end
                                    default:
                                    begin
                                        if (word_next != ACCEPT_SUCCESS)
                                        begin
                                            push_data.status = ST_ACCEPT;
                                            stop             = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_BODY;
                                        end
                                    end
                                endcase
                                if (stop)
                                begin
                                    push                  = 1'b1;
                                    push_data.record_last = 1'b1;
                                end
                            end
                        end
                    endcase

                    if (!stop)
                    begin
                        if (frag_rem_next != '0)
                        begin
                            if (body_hit)
                            begin
                                push                 = 1'b1;
                                push_data.body_byte  = stream.data_byte;
                                push_data.byte_valid = 1'b1;
                            end
                        end
                        else
                        begin
                            frag_end = 1'b1;
                        end
                    end
                end

                if (frag_end)
                begin
                    if (!frag_last_next)
                    begin
                        hdr_cnt_next = '0;
                        if (body_hit)
                        begin
                            push                 = 1'b1;
                            push_data.body_byte  = stream.data_byte;
                            push_data.byte_valid = 1'b1;
                        end
                    end
                    else if (phase_next == PH_BODY)
                    begin
                        push                  = 1'b1;
                        push_data.body_byte   = body_hit ? stream.data_byte : '0;
                        push_data.byte_valid  = body_hit;
                        push_data.record_last = 1'b1;
                        push_data.status      = ST_OK;
                    end
                    else
                    begin
                        push                  = 1'b1;
                        push_data.record_last = 1'b1;
                        push_data.status      = ST_SHORT;
                    end
                end

                if (push && push_data.record_last)
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_body_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!push_data.byte_valid || push_data.status == ST_OK))
        else $error("body byte pushed with an error status");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.record_last) |=> (phase_reg == PH_IDLE))
        else $error("parser did not go idle after record end");

    a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= HDR_BYTES)
        else $error("fragment header count out of range");
`endif

endmodule

>>> hdl/rrd_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Short queue between the parsing front end and the output stage.
// ----------------------------------------------------------------------------
module rrd_queue
    import rrd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_t       push_data,
    input  logic          pop,
    output result_t       pop_data,
    output queue_status_t status
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue underflow");
`endif

endmodule

>>> hdl/rrd_back.sv
// ----------------------------------------------------------------------------
// Output stage
// Takes results from the queue into an output register and presents them on
// the reply channel.
// ----------------------------------------------------------------------------
module rrd_back
    import rrd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  result_t       q_data,
    output logic          pop,
    rrd_reply_if.source   reply
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop        = !q_status.empty && (!valid_reg || reply.ready);
    assign valid_next = pop || (valid_reg && !reply.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= q_data;
        end
    end

    assign reply.valid       = valid_reg;
    assign reply.body_byte   = data_reg.body_byte;
    assign reply.byte_valid  = data_reg.byte_valid;
    assign reply.record_last = data_reg.record_last;
    assign reply.status      = data_reg.status;

endmodule
